### design/five_bit_to_prefix_code_transcoder_assert.svh
`ifndef FIVE_BIT_TO_PREFIX_CODE_TRANSCODER_ASSERT_SVH
`define FIVE_BIT_TO_PREFIX_CODE_TRANSCODER_ASSERT_SVH

// Property that holds at every clock edge outside reset.
`define FBPC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define FBPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/fbpc_pkg.sv
package fbpc_pkg;

  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

  typedef struct packed {
    logic [7:0] in_char;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_item_t;

  // Decoded characters of one input word, oldest in ch0.
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] ch0;
    logic [7:0] ch1;
  } dec_res_t;

  typedef struct packed {
    logic       valid;
    logic [4:0] idx;
  } sym_t;

  typedef struct packed {
    logic [3:0] len;
    logic [7:0] ch;
  } code_t;

  function automatic sym_t sym_map(input logic [7:0] c);
    sym_t s;
    s.valid = 1'b1;
    s.idx   = 5'd0;
    case (c) inside
      [8'h41:8'h5A]: s.idx = 5'(c - 8'h41);
      8'h20:         s.idx = 5'd26;
      8'h2E:         s.idx = 5'd27;
      8'h2C:         s.idx = 5'd28;
      8'h2D:         s.idx = 5'd29;
      8'h27:         s.idx = 5'd30;
      8'h3F:         s.idx = 5'd31;
      default:       s.valid = 1'b0;
    endcase
    return s;
  endfunction

  // The code is complete: any 8-bit window starts with exactly one codeword.
  function automatic code_t decode8(input logic [7:0] w);
    code_t d;
    d.len = 4'd8;
    d.ch  = 8'h5A;
    case (w) inside
      8'b101?????: begin d.len = 4'd3; d.ch = 8'h20; end
      8'b110?????: begin d.len = 4'd3; d.ch = 8'h45; end
      8'b111?????: begin d.len = 4'd3; d.ch = 8'h50; end
      8'b0101????: begin d.len = 4'd4; d.ch = 8'h43; end
      8'b0001????: begin d.len = 4'd4; d.ch = 8'h44; end
      8'b0111????: begin d.len = 4'd4; d.ch = 8'h49; end
      8'b0110????: begin d.len = 4'd4; d.ch = 8'h4B; end
      8'b1000????: begin d.len = 4'd4; d.ch = 8'h52; end
      8'b01001???: begin d.len = 4'd5; d.ch = 8'h46; end
      8'b00100???: begin d.len = 4'd5; d.ch = 8'h4C; end
      8'b00101???: begin d.len = 4'd5; d.ch = 8'h4F; end
      8'b00110???: begin d.len = 4'd5; d.ch = 8'h53; end
      8'b00111???: begin d.len = 4'd5; d.ch = 8'h54; end
      8'b000000??: begin d.len = 4'd6; d.ch = 8'h27; end
      8'b000011??: begin d.len = 4'd6; d.ch = 8'h2C; end
      8'b010001??: begin d.len = 4'd6; d.ch = 8'h2E; end
      8'b000001??: begin d.len = 4'd6; d.ch = 8'h3F; end
      8'b100101??: begin d.len = 4'd6; d.ch = 8'h41; end
      8'b010000??: begin d.len = 4'd6; d.ch = 8'h48; end
      8'b000010??: begin d.len = 4'd6; d.ch = 8'h57; end
      8'b10010001: d.ch = 8'h2D;
      8'b10011010: d.ch = 8'h42;
      8'b10011011: d.ch = 8'h47;
      8'b10011000: d.ch = 8'h4A;
      8'b10011001: d.ch = 8'h4D;
      8'b10011110: d.ch = 8'h4E;
      8'b10011111: d.ch = 8'h51;
      8'b10011100: d.ch = 8'h55;
      8'b10011101: d.ch = 8'h56;
      8'b10010010: d.ch = 8'h58;
      8'b10010011: d.ch = 8'h59;
      default:     d.ch = 8'h5A;
    endcase
    return d;
  endfunction

endpackage

### design/fbpc_core.sv
module fbpc_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  fbpc_pkg::in_item_t item,
  output fbpc_pkg::dec_res_t res
);

  logic [6:0] pend_bits, pend_bits_next;
  logic [2:0] pend_cnt, pend_cnt_next;

  fbpc_pkg::sym_t  sm;
  fbpc_pkg::code_t d0, d1;
  logic [11:0] acc, win, win2;
  logic [3:0]  total, rem0, keep;
  logic        m0, m1;

  always_comb begin
    sm    = fbpc_pkg::sym_map(item.in_char);
    acc   = {pend_bits, sm.idx};
    total = {1'b0, pend_cnt} + 4'd5;
    // left-align the valid bits so each window starts at bit 11
    win   = acc << (4'd12 - total);
    d0    = fbpc_pkg::decode8(win[11:4]);
    m0    = d0.len <= total;
    rem0  = m0 ? total - d0.len : total;
    win2  = win << d0.len;
    d1    = fbpc_pkg::decode8(win2[11:4]);
    m1    = m0 && (d1.len <= rem0);
    keep  = m1 ? rem0 - d1.len : rem0;

    res.cnt        = 2'd0;
    res.ch0        = d0.ch;
    res.ch1        = d1.ch;
    pend_bits_next = pend_bits;
    pend_cnt_next  = pend_cnt;
    if (item.line_end) begin
      res.cnt        = 2'd1;
      res.ch0        = fbpc_pkg::NEWLINE_CHAR;
      pend_bits_next = 7'd0;
      pend_cnt_next  = 3'd0;
    end else if (sm.valid) begin
      res.cnt        = {m1, m0 & ~m1};
      pend_cnt_next  = keep[2:0];
      pend_bits_next = acc[6:0] & ((7'd1 << keep[2:0]) - 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits <= 7'd0;
      pend_cnt  <= 3'd0;
    end else if (advance) begin
      pend_bits <= pend_bits_next;
      pend_cnt  <= pend_cnt_next;
    end
  end

endmodule

### design/fbpc_out_buf.sv
`include "five_bit_to_prefix_code_transcoder_assert.svh"

module fbpc_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  fbpc_pkg::dec_res_t  res,
  output logic                load_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output fbpc_pkg::out_item_t out_data
);

  logic [1:0] cnt;
  logic [7:0] slot0, slot1;
  logic       fire;

  assign out_valid         = cnt != 2'd0;
  assign fire              = out_valid && out_ready;
  assign out_data.out_char = slot0;
  assign out_data.last     = cnt == 2'd1;
  // take new results when empty or when the final word leaves this cycle
  assign load_ok           = (cnt == 2'd0) || ((cnt == 2'd1) && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= res.cnt;
    end else if (fire) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot0 <= res.ch0;
      slot1 <= res.ch1;
    end else if (fire) begin
      slot0 <= slot1;
    end
  end

  `FBPC_ASSERT(a_cnt_range, clk, rst, cnt != 2'd3, "result count out of range")
  `FBPC_ASSERT(a_load_safe, clk, rst, !load || cnt == 2'd0 || (cnt == 2'd1 && fire), "load overwrites pending word")
  `FBPC_ASSERT_NEXT(a_second_word, clk, rst, fire && cnt == 2'd2 && !load, cnt == 2'd1 && slot0 == $past(slot1), "second word not advanced")

endmodule

### design/five_bit_to_prefix_code_transcoder.sv
// Five-bit to prefix-code transcoder.
// Input channel (in_valid/in_ready/in_data): one ASCII character per word, or
// a line end. Alphabet characters add five bits (A-Z, space . , - ' ?) to a
// small pending buffer; other characters add nothing. The bits are decoded
// with a fixed prefix code of 3 to 8 bits.
// Output channel (out_valid/out_ready/out_data): decoded characters, zero to
// two per input word; last marks the final one. A line end gives a single
// newline word with last set and drops the pending bits.
// The first result word passes the input register, then the result register,
// before it is offered.
// Throughput: one input word per cycle when it yields at most one result and
// out_ready is high; a word that yields two holds the next input word back until
// its first result is taken; the single-word output port sets this. A new input
// word is taken while the last result of the previous one is being handed off.
// When the receiver stalls, results hold in the result register, then the input register fills and in_ready drops.
// Reset (rst, synchronous) empties both registers and clears pending bits.
module five_bit_to_prefix_code_transcoder (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  fbpc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fbpc_pkg::out_item_t out_data
);

  fbpc_pkg::in_item_t in_q;
  logic               in_q_valid;
  logic               load_ok, advance;
  fbpc_pkg::dec_res_t res;

  assign advance  = in_q_valid && load_ok;
  assign in_ready = !in_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_data;
    end
  end

  fbpc_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_q),
    .res     (res)
  );

  fbpc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res       (res),
    .load_ok   (load_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### test/prefix_decode_checker.sv
module prefix_decode_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  fbpc_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  fbpc_pkg::out_item_t out_data,
  output int                  errors,
  output int                  queued
);

  localparam logic [255:0] SYMBOLS = "ABCDEFGHIJKLMNOPQRSTUVWXYZ .,-'?";
  localparam logic [7:0]   NO_CODE = 8'h00;
  localparam int           MAX_CODE_LEN = 8;

  logic [6:0]          pend_bits;
  int                  pend_cnt;
  fbpc_pkg::out_item_t expected_chars[$];

  function automatic int symbol_of(input logic [7:0] c);
    for (int k = 0; k < 32; k++) begin
      if (SYMBOLS[255 - 8 * k -: 8] == c) return k;
    end
    return -1;
  endfunction

  function automatic logic [7:0] code_char(input logic [3:0] len, input logic [7:0] val);
    case ({len, val})
      {4'd3, 8'h05}: return " ";
      {4'd3, 8'h06}: return "E";
      {4'd3, 8'h07}: return "P";
      {4'd4, 8'h01}: return "D";
      {4'd4, 8'h05}: return "C";
      {4'd4, 8'h06}: return "K";
      {4'd4, 8'h07}: return "I";
      {4'd4, 8'h08}: return "R";
      {4'd5, 8'h04}: return "L";
      {4'd5, 8'h05}: return "O";
      {4'd5, 8'h06}: return "S";
      {4'd5, 8'h07}: return "T";
      {4'd5, 8'h09}: return "F";
      {4'd6, 8'h00}: return "'";
      {4'd6, 8'h01}: return "?";
      {4'd6, 8'h02}: return "W";
      {4'd6, 8'h03}: return ",";
      {4'd6, 8'h10}: return "H";
      {4'd6, 8'h11}: return ".";
      {4'd6, 8'h25}: return "A";
      {4'd8, 8'h90}: return "Z";
      {4'd8, 8'h91}: return "-";
      {4'd8, 8'h92}: return "X";
      {4'd8, 8'h93}: return "Y";
      {4'd8, 8'h98}: return "J";
      {4'd8, 8'h99}: return "M";
      {4'd8, 8'h9A}: return "B";
      {4'd8, 8'h9B}: return "G";
      {4'd8, 8'h9C}: return "U";
      {4'd8, 8'h9D}: return "V";
      {4'd8, 8'h9E}: return "N";
      {4'd8, 8'h9F}: return "Q";
      default:       return NO_CODE;
    endcase
  endfunction

  // Append the five bits of one character and queue every completed codeword.
  task automatic decode_word(input fbpc_pkg::in_item_t w);
    int                  sym;
    int                  total;
    int                  pos;
    int                  len;
    int                  n;
    logic [11:0]         acc;
    logic [7:0]          val;
    logic [7:0]          ch;
    fbpc_pkg::out_item_t got[2];
    if (w.line_end) begin
      pend_bits = '0;
      pend_cnt  = 0;
      got[0].out_char = fbpc_pkg::NEWLINE_CHAR;
      got[0].last     = 1'b1;
      expected_chars.push_back(got[0]);
      return;
    end
    sym = symbol_of(w.in_char);
    if (sym < 0) return;
    total = pend_cnt + 5;
    acc   = {pend_bits, 5'(sym)};
    pos   = 0;
    len   = 1;
    n     = 0;
    while (pos + len <= total) begin
      val = 8'((acc >> (total - pos - len)) & ((12'd1 << len) - 12'd1));
      ch  = (len <= MAX_CODE_LEN) ? code_char(4'(len), val) : NO_CODE;
      if (ch != NO_CODE) begin
        if (n < 2) begin
          got[n].out_char = ch;
          got[n].last     = 1'b0;
          n++;
        end
        pos += len;
        len = 1;
      end else begin
        len++;
      end
    end
    for (int k = 0; k < n; k++) begin
      if (k == n - 1) got[k].last = 1'b1;
      expected_chars.push_back(got[k]);
    end
    pend_cnt  = total - pos;
    pend_bits = 7'(acc & ((12'd1 << pend_cnt) - 12'd1));
  endtask

  always @(posedge clk) begin
    fbpc_pkg::out_item_t want;
    if (rst) begin
      pend_bits = '0;
      pend_cnt  = 0;
      expected_chars.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected word: out_char %02h, last %0b", out_data.out_char, out_data.last);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (out_data.out_char !== want.out_char) begin
            $error("out_char: expected %02h, got %02h", want.out_char, out_data.out_char);
            errors++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_data.last);
            errors++;
          end
        end
      end
      // Results of a word pass the input and result registers before they show up, so pop first.
      if (in_valid && in_ready) decode_word(in_data);
    end
    queued = expected_chars.size();
  end

endmodule

### test/testbench.sv
module testbench;

  localparam logic [255:0] SYMBOLS         = "ABCDEFGHIJKLMNOPQRSTUVWXYZ .,-'?";
  localparam int           ITEMS           = 1350;
  localparam int           LIMIT           = 600000;
  localparam int           PRESSURE_A      = 300;
  localparam int           PRESSURE_B      = 1500;
  localparam int           PRESSURE_CYCLES = 250;
  localparam int           DRAIN_CYCLES    = 10;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  fbpc_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  fbpc_pkg::out_item_t out_data;
  int                  errors;
  int                  queued;
  int                  cycles    = 0;
  bit                  steady    = 1'b0;

  always #5 clk = ~clk;

  five_bit_to_prefix_code_transcoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  prefix_decode_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .errors    (errors),
    .queued    (queued)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("five_bit_to_prefix_code_transcoder regression: fail");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one word after a random gap and hold it until it is taken.
  task automatic put_word(input logic [7:0] c, input logic le);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{in_char: c, line_end: le};
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [7:0] symbol_char(input int k);
    return SYMBOLS[255 - 8 * k -: 8];
  endfunction

  // Receiver: random back-pressure, calm stretches, and two long hold-offs.
  initial begin
    int  hold;
    int  r;
    bit  eager;
    hold  = 0;
    eager = 1'b0;
    @(posedge clk);
    forever begin
      if (cycles % 200 == 0) eager = ($urandom_range(0, 2) == 0);
      if (cycles == PRESSURE_A || cycles == PRESSURE_B) hold = PRESSURE_CYCLES;
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (eager) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          hold = $urandom_range(10, 40);
          out_ready <= 1'b0;
        end else begin
          out_ready <= (r >= 25);
        end
      end
      @(posedge clk);
    end
  end

  initial begin
    int counted;
    int line_len;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, non-alphabet bytes, line ends, one and two results.
    put_word(8'h0A, 1'b1);
    put_word("A", 1'b0);
    put_word("?", 1'b0);
    put_word("A", 1'b0);
    put_word(8'hFF, 1'b1);
    put_word(8'h00, 1'b0);
    put_word(8'hFF, 1'b0);
    put_word(8'h80, 1'b0);
    put_word("@", 1'b0);
    put_word("[", 1'b0);
    put_word("a", 1'b0);
    put_word("Z", 1'b0);
    put_word("P", 1'b0);
    put_word("W", 1'b0);
    put_word(" ", 1'b0);
    put_word(".", 1'b0);
    put_word(",", 1'b0);
    put_word("-", 1'b0);
    put_word("'", 1'b0);
    put_word("A", 1'b1);
    put_word(8'h00, 1'b1);
    put_word("Q", 1'b0);

    counted = 0;
    while (counted < ITEMS) begin
      steady   = ($urandom_range(0, 3) == 0);
      line_len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 20);
      for (int k = 0; k < line_len; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          put_word(8'($urandom_range(0, 255)), 1'b0);
        end else begin
          put_word(symbol_char($urandom_range(0, 31)), 1'b0);
        end
        counted++;
      end
      // Leave some lines unterminated so pending bits run across them.
      if ($urandom_range(0, 11) != 0) begin
        put_word(8'($urandom_range(0, 255)), 1'b1);
        counted++;
      end
    end
    in_valid <= 1'b0;

    do @(negedge clk); while (queued != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && queued == 0) begin
      $display("five_bit_to_prefix_code_transcoder regression: pass");
    end else begin
      $display("five_bit_to_prefix_code_transcoder regression: fail");
    end
    $finish;
  end

endmodule

### five_bit_to_prefix_code_transcoder.f
+incdir+design
design/fbpc_pkg.sv
design/fbpc_core.sv
design/fbpc_out_buf.sv
design/five_bit_to_prefix_code_transcoder.sv
test/prefix_decode_checker.sv
test/testbench.sv
